### rtl/core/mbps_pkg.sv
package mbps_pkg;

  localparam int MAX_PATTERN_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 48;

  localparam int BYTE_W        = 8;
  localparam int PATTERN_BYTES = 16;
  localparam int LENGTH_W      = 5;
  localparam int RANGE_BASE_W  = 48;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KNOWN_MASK   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### rtl/core/mbps_cell.sv
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  byte_t      din,
  input  logic       care,
  input  byte_t      expected,
  output byte_t      dout,
  output logic       hit
);

  byte_t held;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= ctrl.clear ? '0 : din;
    end
  end

  assign dout = held;
  assign hit  = !care || (held == expected);

endmodule

### rtl/core/masked_byte_pattern_search.sv
// Masked byte pattern search.
// Bytes of one or more memory ranges arrive on the input channel, one byte
// per beat. A beat with range_start set opens a new range at range_base, and
// a beat with search_start set begins a new search. The pattern, its
// wildcard mask and its length are set through the write port; the user
// must do so only while the block is idle, which the block does not
// enforce. The first match of a search gives one output beat with found
// set and the address of the first pattern byte. A search that ends
// without a match gives one beat with found clear on its last byte. The
// block takes one byte per cycle while the output is not stalled. A
// result is registered: the window cells take the byte on acceptance, and
// the compare stage then loads the output register once the output is
// free. When the receiver stalls, the output register holds its beat and
// the cell row holds one further byte; input ready then drops until the
// output beat is taken. Reset clears the pattern registers, sets the length
// to one, empties the pipeline and clears the match flag and range offset.
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int MAX_PATTERN  = MAX_PATTERN_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BYTE_W-1:0]       data_byte,
  input  logic                    range_start,
  input  logic [RANGE_BASE_W-1:0] range_base,
  input  logic                    search_start,
  input  logic                    search_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [RANGE_BASE_W-1:0] found_address
);

  localparam int WIN = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
  localparam int AW  = ADDRESS_BITS;

  logic [CFG_DATA_W-1:0]    pattern_bytes_low;
  logic [CFG_DATA_W-1:0]    pattern_bytes_high;
  logic [PATTERN_BYTES-1:0] known_mask;
  logic [LENGTH_W-1:0]      pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      known_mask         <= '0;
      pattern_length     <= LENGTH_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_bytes_high <= cfg_data;
        REG_KNOWN_MASK:   known_mask         <= cfg_data[PATTERN_BYTES-1:0];
        REG_PATTERN_LEN:  pattern_length     <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LENGTH_W-1:0] eff_len;
  byte_t               pat_arr [PATTERN_BYTES];

  assign eff_len = (pattern_length > LENGTH_W'(WIN)) ? LENGTH_W'(WIN) : pattern_length;

  always_comb begin
    for (int b = 0; b < PATTERN_BYTES; b++) begin
      if (b < 8) begin
        pat_arr[b] = pattern_bytes_low[b*BYTE_W +: BYTE_W];
      end else begin
        pat_arr[b] = pattern_bytes_high[(b-8)*BYTE_W +: BYTE_W];
      end
    end
  end

  logic out_free;
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign accept   = in_valid && in_ready;

  logic [AW-1:0] base_in;
  logic [AW-1:0] offset;
  logic [AW-1:0] offset_next;
  logic [AW-1:0] cur;
  logic [AW-1:0] cur_next;
  logic          offset_max;
  logic          s1_start;
  logic          s1_end;

  if (AW > RANGE_BASE_W) begin : g_base_wide
    assign base_in = {{(AW-RANGE_BASE_W){1'b0}}, range_base};
  end else if (AW == RANGE_BASE_W) begin : g_base_same
    assign base_in = range_base;
  end else begin : g_base_narrow
    assign base_in = range_base[AW-1:0];
  end

  assign offset_max = &offset;

  always_comb begin
    if (range_start) begin
      offset_next = {{(AW-1){1'b0}}, 1'b1};
      cur_next    = base_in + {{(AW-1){1'b0}}, 1'b1};
    end else if (offset_max) begin
      offset_next = offset;
      cur_next    = cur;
    end else begin
      offset_next = offset + {{(AW-1){1'b0}}, 1'b1};
      cur_next    = cur + {{(AW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      offset   <= '0;
      cur      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        offset   <= offset_next;
        cur      <= cur_next;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start <= search_start;
      s1_end   <= search_end;
    end
  end

  byte_t          win      [WIN];
  logic [WIN-1:0] hits;

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic                clr;
    byte_t               din;
    logic [LENGTH_W-1:0] pidx;
    logic                care;
    byte_t               expected;

    assign pidx = eff_len - LENGTH_W'(k) - LENGTH_W'(1);

    if (k == 0) begin : g_head
      assign din = data_byte;
      assign clr = 1'b0;
    end else begin : g_body
      assign din = win[k-1];
      assign clr = range_start;
    end
    assign ctrl = '{shift: accept, clear: clr};

    assign care     = (LENGTH_W'(k) < eff_len) && known_mask[pidx[3:0]];
    assign expected = pat_arr[pidx[3:0]];

    mbps_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .din      (din),
      .care     (care),
      .expected (expected),
      .dout     (win[k]),
      .hit      (hits[k])
    );
  end

  logic          match_seen;
  logic          seen_eff;
  logic          is_match;
  logic          res_valid;
  logic [AW-1:0] addr_full;
  logic [RANGE_BASE_W-1:0] addr_out;

  assign seen_eff  = match_seen && !s1_start;
  assign is_match  = !seen_eff && (eff_len != '0) && (offset >= AW'(eff_len)) && (&hits);
  assign res_valid = is_match || (s1_end && !seen_eff);
  assign addr_full = cur - AW'(eff_len);

  if (AW >= RANGE_BASE_W) begin : g_out_wide
    assign addr_out = addr_full[RANGE_BASE_W-1:0];
  end else begin : g_out_narrow
    assign addr_out = {{(RANGE_BASE_W-AW){1'b0}}, addr_full};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        match_seen <= seen_eff || is_match;
      end
      if (s1_adv && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      found         <= is_match;
      found_address <= is_match ? addr_out : '0;
    end
  end

endmodule
